// ===== design/tlpt_pkg.sv =====
package tlpt_pkg;

    // Geometry fixed by the 32-bit, 4 KiB page address split
    localparam int ADDR_W          = 32;
    localparam int DIR_ENTRIES     = 1024;
    localparam int TABLE_ENTRIES   = 1024;
    localparam int TABLE_SLOTS_DEF = 16;
    localparam int PAGE_SHIFT      = 12;
    localparam int DIR_SHIFT       = 22;
    localparam int IDX_W           = $clog2(DIR_ENTRIES);
    localparam int OFF_W           = PAGE_SHIFT;
    localparam int FRAME_W         = ADDR_W - PAGE_SHIFT;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Command codes
    localparam logic [1:0] CMD_TRANSLATE = 2'd0;
    localparam logic [1:0] CMD_MAP       = 2'd1;
    localparam logic [1:0] CMD_UNMAP     = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK            = 2'd0;
    localparam logic [1:0] ST_NOT_MAPPED    = 2'd1;
    localparam logic [1:0] ST_MISALIGNED    = 2'd2;
    localparam logic [1:0] ST_OUT_OF_TABLES = 2'd3;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ADDR_W-1:0] virt_addr;
        logic [ADDR_W-1:0] map_phys;
        logic              user_flag;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0] phys_addr;
        logic [1:0]        status;
    } t_out_item;

    // Classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_TRANSLATE,
        OP_MAP,
        OP_UNMAP,
        OP_NOP,
        OP_MISALIGNED
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   dir_idx;
        logic [IDX_W-1:0]   tab_idx;
        logic [OFF_W-1:0]   offset;
        logic [FRAME_W-1:0] frame;
        logic               user;
    } t_work;

    // Page table entry
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               user;
        logic               wr;
        logic               present;
    } t_pte;

endpackage

// ===== design/two_level_page_table_engine.sv =====
// The back end works on one item at a time: it takes the next item from the queue only when idle
//   and the result register is free. A translate does the directory read and then the dependent
//   table read, and an allocating map holds the back end while its new table slot is swept.
// Reset (i_rst_n low, synchronous): queue and result emptied, then a directory clearing pass.
module two_level_page_table_engine #(
    parameter int TABLE_SLOTS = tlpt_pkg::TABLE_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  tlpt_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output tlpt_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);
    import tlpt_pkg::*;

    // Front: takes a beat, decodes the command and checks alignment.
    // Queue: two entries, so the front keeps taking beats while the back walks.
    // Back: owns the directory and table pool RAMs, does the walk, allocates and
    //   clears table slots, and holds the result in a register until it is taken.

    t_work front_work;
    t_work q_head;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    logic  clearing;

    tlpt_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .i_clearing (clearing),
        .o_push     (q_push),
        .o_work     (front_work)
    );

    tlpt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_work),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_head),
        .o_empty (q_empty)
    );

    // Slots are handed out in order and never freed; a new slot is swept (one entry a cycle),
    // zero except for the new mapping's entry, before the mapping beat completes.
    tlpt_back #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work       (q_head),
        .i_work_avail (!q_empty),
        .o_pop        (q_pop),
        .o_clearing   (clearing),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

endmodule

// ===== design/tlpt_front.sv =====
module tlpt_front (
    input  logic              i_in_valid,
    input  tlpt_pkg::t_in_item i_in_data,
    output logic              o_in_stall,
    input  logic              i_q_full,
    input  logic              i_clearing,
    output logic              o_push,
    output tlpt_pkg::t_work   o_work
);
    import tlpt_pkg::*;

    logic misaligned;

    assign o_in_stall = i_q_full || i_clearing;
    assign o_push     = i_in_valid && !o_in_stall;

    // map needs both addresses page aligned
    assign misaligned = (i_in_data.virt_addr[OFF_W-1:0] != '0) ||
                        (i_in_data.map_phys[OFF_W-1:0] != '0);

    always_comb begin
        o_work.dir_idx = i_in_data.virt_addr[DIR_SHIFT +: IDX_W];
        o_work.tab_idx = i_in_data.virt_addr[PAGE_SHIFT +: IDX_W];
        o_work.offset  = i_in_data.virt_addr[OFF_W-1:0];
        o_work.frame   = i_in_data.map_phys[PAGE_SHIFT +: FRAME_W];
        o_work.user    = i_in_data.user_flag;
        unique case (i_in_data.cmd)
            CMD_TRANSLATE: o_work.op = OP_TRANSLATE;
            CMD_MAP:       o_work.op = misaligned ? OP_MISALIGNED : OP_MAP;
            CMD_UNMAP:     o_work.op = OP_UNMAP;
            default:       o_work.op = OP_NOP;
        endcase
    end

endmodule

// ===== design/tlpt_fifo.sv =====
module tlpt_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tlpt_pkg::t_work i_data,
    output logic            o_full,
    input  logic            i_pop,
    output tlpt_pkg::t_work o_data,
    output logic            o_empty
);
    import tlpt_pkg::*;

    t_work             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/tlpt_back.sv =====
module tlpt_back #(
    parameter int TABLE_SLOTS = tlpt_pkg::TABLE_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tlpt_pkg::t_work     i_work,
    input  logic                i_work_avail,
    output logic                o_pop,
    output logic                o_clearing,
    output logic                o_out_valid,
    output tlpt_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);
    import tlpt_pkg::*;

    localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W      = $clog2(TABLE_SLOTS + 1);
    localparam int POOL_DEPTH = TABLE_SLOTS * TABLE_ENTRIES;
    localparam int POOL_AW    = SLOT_W + IDX_W;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              user;
        logic              wr;
        logic              present;
    } t_dir_entry;

    typedef enum logic [2:0] {
        S_CLEAR_DIR,
        S_IDLE,
        S_DIR,
        S_POOL,
        S_CLEAR_SLOT
    } t_state;

    t_state            r_state;
    t_work             r_work;
    logic [IDX_W-1:0]  r_sweep;
    logic [CNT_W-1:0]  r_next_free;
    logic [SLOT_W-1:0] r_alloc_slot;
    logic              r_out_valid;
    t_out_item         r_out_data;

    t_dir_entry r_dir_mem [DIR_ENTRIES];
    t_dir_entry r_dir_rd;
    t_pte       r_pool_mem [POOL_DEPTH];
    t_pte       r_pool_rd;

    logic               dir_we;
    logic [IDX_W-1:0]   dir_wa;
    t_dir_entry         dir_wd;
    logic               pool_we;
    logic [POOL_AW-1:0] pool_wa;
    t_pte               pool_wd;
    logic [POOL_AW-1:0] pool_ra;
    logic               out_free;
    logic               out_load;
    logic               dir_hit;
    logic               alloc_ok;
    logic               sweep_last;
    t_pte               new_pte;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_pop      = (r_state == S_IDLE) && i_work_avail && out_free;
    assign o_clearing = (r_state == S_CLEAR_DIR);
    assign dir_hit    = r_dir_rd.present;
    assign alloc_ok   = (r_next_free < CNT_W'(TABLE_SLOTS));
    assign sweep_last = (r_sweep == IDX_W'(TABLE_ENTRIES - 1));
    assign pool_ra    = {r_dir_rd.slot, r_work.tab_idx};

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        new_pte.frame   = r_work.frame;
        new_pte.user    = r_work.user;
        new_pte.wr      = 1'b1;
        new_pte.present = 1'b1;
    end

    // a result is loaded this cycle
    always_comb begin
        case (r_state)
            S_IDLE: begin
                out_load = o_pop && (i_work.op == OP_NOP || i_work.op == OP_MISALIGNED);
            end
            S_DIR: begin
                out_load = !((r_work.op == OP_TRANSLATE && dir_hit) ||
                             (r_work.op == OP_MAP && !dir_hit && alloc_ok));
            end
            S_POOL:       out_load = 1'b1;
            S_CLEAR_SLOT: out_load = sweep_last;
            default:      out_load = 1'b0;
        endcase
    end

    // directory write port
    always_comb begin
        dir_we = 1'b0;
        dir_wa = r_work.dir_idx;
        dir_wd = '0;
        if (r_state == S_CLEAR_DIR) begin
            dir_we = 1'b1;
            dir_wa = r_sweep;
        end else if (r_state == S_DIR && r_work.op == OP_MAP && !dir_hit && alloc_ok) begin
            dir_we         = 1'b1;
            dir_wd.slot    = r_next_free[SLOT_W-1:0];
            dir_wd.user    = r_work.user;
            dir_wd.wr      = 1'b1;
            dir_wd.present = 1'b1;
        end
    end

    // pool write port: mapping, unmapping, or slot clearing sweep
    always_comb begin
        pool_we = 1'b0;
        pool_wa = pool_ra;
        pool_wd = '0;
        if (r_state == S_DIR && dir_hit &&
            (r_work.op == OP_MAP || r_work.op == OP_UNMAP)) begin
            pool_we = 1'b1;
            pool_wd = (r_work.op == OP_MAP) ? new_pte : '0;
        end else if (r_state == S_CLEAR_SLOT) begin
            pool_we = 1'b1;
            pool_wa = {r_alloc_slot, r_sweep};
            pool_wd = (r_sweep == r_work.tab_idx) ? new_pte : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            r_dir_mem[dir_wa] <= dir_wd;
        end
        r_dir_rd <= r_dir_mem[i_work.dir_idx];
    end

    always_ff @(posedge i_clk) begin
        if (pool_we) begin
            r_pool_mem[pool_wa] <= pool_wd;
        end
        r_pool_rd <= r_pool_mem[pool_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR_DIR;
            r_sweep     <= '0;
            r_next_free <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR_DIR: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == IDX_W'(DIR_ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_pop) begin
                        r_work <= i_work;
                        unique case (i_work.op)
                            OP_NOP: begin
                                r_out_valid          <= 1'b1;
                                r_out_data.phys_addr <= '0;
                                r_out_data.status    <= ST_OK;
                            end
                            OP_MISALIGNED: begin
                                r_out_valid          <= 1'b1;
                                r_out_data.phys_addr <= '0;
                                r_out_data.status    <= ST_MISALIGNED;
                            end
                            default: r_state <= S_DIR;
                        endcase
                    end
                end
                S_DIR: begin
                    unique case (r_work.op)
                        OP_TRANSLATE: begin
                            if (dir_hit) begin
                                r_state <= S_POOL;
                            end else begin
                                r_state              <= S_IDLE;
                                r_out_valid          <= 1'b1;
                                r_out_data.phys_addr <= '0;
                                r_out_data.status    <= ST_NOT_MAPPED;
                            end
                        end
                        OP_MAP: begin
                            if (!dir_hit && alloc_ok) begin
                                r_alloc_slot <= r_next_free[SLOT_W-1:0];
                                r_next_free  <= r_next_free + 1'b1;
                                r_sweep      <= '0;
                                r_state      <= S_CLEAR_SLOT;
                            end else begin
                                r_state              <= S_IDLE;
                                r_out_valid          <= 1'b1;
                                r_out_data.phys_addr <= '0;
                                r_out_data.status    <= dir_hit ? ST_OK : ST_OUT_OF_TABLES;
                            end
                        end
                        default: begin
                            r_state              <= S_IDLE;
                            r_out_valid          <= 1'b1;
                            r_out_data.phys_addr <= '0;
                            r_out_data.status    <= ST_OK;
                        end
                    endcase
                end
                S_POOL: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                    if (r_pool_rd.present) begin
                        r_out_data.phys_addr <= {r_pool_rd.frame, r_work.offset};
                        r_out_data.status    <= ST_OK;
                    end else begin
                        r_out_data.phys_addr <= '0;
                        r_out_data.status    <= ST_NOT_MAPPED;
                    end
                end
                S_CLEAR_SLOT: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (sweep_last) begin
                        r_state              <= S_IDLE;
                        r_out_valid          <= 1'b1;
                        r_out_data.phys_addr <= '0;
                        r_out_data.status    <= ST_OK;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== design/tlpt_checker.sv =====
module tlpt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_stall,
    input logic                i_out_valid,
    input tlpt_pkg::t_out_item i_out_data,
    input logic                i_out_stall
);
    import tlpt_pkg::*;

    // coming out of reset: input held off for the clearing pass, no result pending
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_stall && !i_out_valid)
        else $error("not quiet after reset");

    // any failing status carries a zero address
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.status != ST_OK |-> i_out_data.phys_addr == '0)
        else $error("non-zero address with error status");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_out_valid) && $past(i_rst_n) |-> $past(!i_out_stall))
        else $error("result dropped without being taken");

endmodule

bind two_level_page_table_engine tlpt_checker u_tlpt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

// ===== test/tb_two_level_page_table_engine.sv =====
`timescale 1ns / 100ps

module tb_two_level_page_table_engine;

    import tlpt_pkg::*;

    // Pool size of the instance below (default parameter)
    localparam int POOL_SLOTS = TABLE_SLOTS_DEF;

    // The block answers command code 3 with a plain ok and no side effects
    localparam logic [1:0] CMD_UNDEFINED = 2'd3;

    // Number of random beats after the directed tests
    localparam int RANDOM_BEATS = 1350;

    // Receiver back-pressure styles; one is picked for each stretch of cycles
    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_style;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      i_out_stall = 1'b0;

    two_level_page_table_engine uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // ------------------------------------------------------------------
    // Shadow page tables
    // ------------------------------------------------------------------
    // Directory: present, user mark and slot number per entry. The write bit
    // is always set on allocation, so it is not kept.
    bit          dir_present [DIR_ENTRIES];
    bit          dir_user    [DIR_ENTRIES];
    int unsigned dir_slot    [DIR_ENTRIES];
    // Table pool, slot-major. An entry is only read once its slot has been
    // allocated (and thereby cleared), so no start-up clear is needed.
    t_pte        page_pool   [POOL_SLOTS*TABLE_ENTRIES];
    int unsigned slots_taken = 0;

    // Results still owed by the block, oldest first
    t_out_item   walk_results_due[$];

    int          mismatch_count = 0;
    int          burst_left     = 0;
    t_stall_style stall_style   = STALL_NONE;
    int          style_left     = 0;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Works out the answer to one command and updates the shadow tables
    // the way the block is meant to.
    function automatic t_out_item predict_walk_result(input t_in_item it);
        t_out_item        res;
        logic [IDX_W-1:0] di;
        logic [IDX_W-1:0] ti;
        int unsigned      pidx;
        int unsigned      base;
        res.phys_addr = '0;
        res.status    = ST_OK;
        di            = it.virt_addr[31:DIR_SHIFT];
        ti            = it.virt_addr[DIR_SHIFT-1:PAGE_SHIFT];
        pidx          = dir_slot[di] * TABLE_ENTRIES + ti;
        case (it.cmd)
            CMD_TRANSLATE: begin
                // miss at either level gives zero and not_mapped
                if (dir_present[di] && page_pool[pidx].present) begin
                    res.phys_addr = {page_pool[pidx].frame, it.virt_addr[OFF_W-1:0]};
                end else begin
                    res.status = ST_NOT_MAPPED;
                end
            end
            CMD_MAP: begin
                if ((|it.virt_addr[OFF_W-1:0]) || (|it.map_phys[OFF_W-1:0])) begin
                    res.status = ST_MISALIGNED;
                end else begin
                    if (!dir_present[di]) begin
                        if (slots_taken >= POOL_SLOTS) begin
                            res.status = ST_OUT_OF_TABLES;
                        end else begin
                            base = slots_taken * TABLE_ENTRIES;
                            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                                page_pool[base + k] = '0;
                            end
                            dir_present[di] = 1'b1;
                            dir_user[di]    = it.user_flag;
                            dir_slot[di]    = slots_taken;
                            slots_taken++;
                        end
                    end
                    if (res.status == ST_OK) begin
                        // directory user mark stays as set on allocation
                        pidx = dir_slot[di] * TABLE_ENTRIES + ti;
                        page_pool[pidx] = '{frame:   it.map_phys[ADDR_W-1:PAGE_SHIFT],
                                            user:    it.user_flag,
                                            wr:      1'b1,
                                            present: 1'b1};
                    end
                end
            end
            CMD_UNMAP: begin
                // absent directory entry: nothing to clear, still ok
                if (dir_present[di]) begin
                    page_pool[pidx] = '0;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic t_in_item walk_item(input logic [1:0] op, input logic [31:0] va,
                                           input logic [31:0] pa, input logic usr);
        t_in_item it;
        it.cmd       = op;
        it.virt_addr = va;
        it.map_phys  = pa;
        it.user_flag = usr;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one beat per call. Beats go out in bursts; between bursts the
    // valid drops for a random gap. Long bursts give stretches of back-to-back
    // traffic. Valid is only lowered when a gap is taken, so a beat that
    // follows within a burst never sees valid dropped and raised in one step.
    // ------------------------------------------------------------------
    task automatic send_walk(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 10);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        // beat taken at the first edge with stall low
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        walk_results_due.push_back(predict_walk_result(it));
        burst_left--;
    endtask

    // ------------------------------------------------------------------
    // Result checker and receiver back-pressure
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (walk_results_due.size() == 0) begin
                $error("result beat with none outstanding: phys_addr %h status %0d",
                       o_out_data.phys_addr, o_out_data.status);
                mismatch_count++;
            end else begin
                want = walk_results_due.pop_front();
                if (o_out_data.phys_addr !== want.phys_addr) begin
                    $error("phys_addr: expected %h, got %h", want.phys_addr,
                           o_out_data.phys_addr);
                    mismatch_count++;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                    mismatch_count++;
                end
            end
        end
        // new stall style picked whenever the current stretch runs out
        if (style_left == 0) begin
            stall_style = t_stall_style'($urandom_range(0, 3));
            style_left  = $urandom_range(20, 200);
        end
        style_left--;
        case (stall_style)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_RANDOM:   i_out_stall <= ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: i_out_stall <= (style_left % 3 == 0);
            default:        i_out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------
    // Nothing mapped yet: translate misses, unmap of an absent directory
    // entry is a quiet ok.
    task automatic test_empty_tables;
        send_walk(walk_item(CMD_TRANSLATE, 32'h1234_5678, 32'h0, 1'b0));
        send_walk(walk_item(CMD_UNMAP, 32'h0040_0ABC, 32'h0, 1'b1));
    endtask

    // Unaligned virtual or physical address must be refused without
    // allocating a table.
    task automatic test_misaligned_map;
        send_walk(walk_item(CMD_MAP, 32'h0000_1001, 32'h0000_3000, 1'b1));
        send_walk(walk_item(CMD_MAP, 32'h0000_2000, 32'h0000_2800, 1'b0));
    endtask

    // Lowest and highest pages, all-ones and all-zero frames, full offset
    task automatic test_map_extremes;
        send_walk(walk_item(CMD_MAP, 32'h0000_0000, 32'hFFFF_F000, 1'b1));
        send_walk(walk_item(CMD_TRANSLATE, 32'h0000_0FFF, 32'h0, 1'b0));
        send_walk(walk_item(CMD_MAP, 32'hFFFF_F000, 32'h0000_0000, 1'b0));
        send_walk(walk_item(CMD_TRANSLATE, 32'hFFFF_F000, 32'h0, 1'b0));
        send_walk(walk_item(CMD_TRANSLATE, 32'hFFFF_FABC, 32'h0, 1'b1));
    endtask

    // Second page under an existing directory entry, then overwrite of a
    // present table entry.
    task automatic test_remap_shared_dir;
        send_walk(walk_item(CMD_MAP, 32'hFFC0_0000, 32'h5A5A_5000, 1'b1));
        send_walk(walk_item(CMD_MAP, 32'hFFFF_F000, 32'hA5A5_A000, 1'b1));
        send_walk(walk_item(CMD_TRANSLATE, 32'hFFC0_0123, 32'h0, 1'b0));
        send_walk(walk_item(CMD_TRANSLATE, 32'hFFFF_F456, 32'h0, 1'b0));
    endtask

    // Unmap ignores the offset bits and leaves neighbours alone
    task automatic test_unmap;
        send_walk(walk_item(CMD_UNMAP, 32'hFFFF_F123, 32'hFFFF_FFFF, 1'b1));
        send_walk(walk_item(CMD_TRANSLATE, 32'hFFFF_F000, 32'h0, 1'b0));
        send_walk(walk_item(CMD_TRANSLATE, 32'hFFC0_0010, 32'h0, 1'b0));
        send_walk(walk_item(CMD_UNMAP, 32'hFFFF_F000, 32'h0, 1'b0));
    endtask

    // Undefined command: zero, ok, no change to the tables
    task automatic test_undefined_cmd;
        send_walk(walk_item(CMD_UNDEFINED, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
        send_walk(walk_item(CMD_UNDEFINED, 32'hFFFF_FFFF, 32'hFFFF_F000, 1'b0));
        send_walk(walk_item(CMD_TRANSLATE, 32'h0000_0000, 32'h0, 1'b0));
    endtask

    // ------------------------------------------------------------------
    // Random traffic. Addresses come mostly from a small set of directory
    // and table indexes so that maps, translates and unmaps meet each other;
    // with more directory picks than table slots the pool runs dry part way
    // through and out_of_tables turns up. A share of fully random addresses
    // and noise beats covers every bit.
    // ------------------------------------------------------------------
    task automatic test_random_traffic(input int n_beats);
        logic [IDX_W-1:0] dir_pick [24];
        logic [IDX_W-1:0] tab_pick [12];
        t_in_item         it;
        int               r;
        dir_pick[0] = '0;
        dir_pick[1] = '1;
        for (int i = 2; i < 24; i++) dir_pick[i] = IDX_W'($urandom);
        tab_pick[0] = '0;
        tab_pick[1] = '1;
        for (int i = 2; i < 12; i++) tab_pick[i] = IDX_W'($urandom);
        repeat (n_beats) begin
            r            = $urandom_range(0, 99);
            it.virt_addr = {dir_pick[$urandom_range(0, 23)], tab_pick[$urandom_range(0, 11)],
                            12'h000};
            if ($urandom_range(0, 9) == 0) it.virt_addr[31:PAGE_SHIFT] = FRAME_W'($urandom);
            it.map_phys           = $urandom;
            it.map_phys[OFF_W-1:0] = '0;
            it.user_flag          = 1'($urandom);
            if (r < 45) begin
                it.cmd                  = CMD_TRANSLATE;
                it.virt_addr[OFF_W-1:0] = OFF_W'($urandom);
            end else if (r < 73) begin
                it.cmd = CMD_MAP;
            end else if (r < 78) begin
                // broken map: one of the two addresses off a page boundary
                it.cmd = CMD_MAP;
                if ($urandom_range(0, 1) == 0) begin
                    it.virt_addr[OFF_W-1:0] = OFF_W'($urandom_range(1, 4095));
                end else begin
                    it.map_phys[OFF_W-1:0] = OFF_W'($urandom_range(1, 4095));
                end
            end else if (r < 92) begin
                it.cmd                  = CMD_UNMAP;
                it.virt_addr[OFF_W-1:0] = OFF_W'($urandom);
            end else if (r < 96) begin
                it.cmd = CMD_UNDEFINED;
            end else begin
                it.cmd       = 2'($urandom);
                it.virt_addr = $urandom;
                it.map_phys  = $urandom;
            end
            send_walk(it);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence. Reset once; the block then runs its directory clearing pass
    // with the input stalled, which the first beat simply waits out.
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_tables;
        test_misaligned_map;
        test_map_extremes;
        test_remap_shared_dir;
        test_unmap;
        test_undefined_cmd;
        test_random_traffic(RANDOM_BEATS);

        i_in_valid <= 1'b0;
        while (walk_results_due.size() != 0) @(posedge i_clk);
        // then wait on to catch any stray result beat
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_two_level_page_table_engine passed");
        end else begin
            $display("tb_two_level_page_table_engine failed");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest legal run (clearing pass, sixteen
    // table allocations, every beat under the longest gaps and stalls)
    initial begin
        #2_000_000;
        $display("tb_two_level_page_table_engine failed");
        $finish;
    end

endmodule
